// File: design/cfc_pkg.sv
package cfc_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned ANGLE_FRAC_DEF   = 8;

	// datapath widths
	localparam int CW   = 28;  // CORDIC x/y/z
	localparam int MA_W = 40;  // multiplier operand a
	localparam int MB_W = 28;  // multiplier operand b (serial side)
	localparam int MP_W = MA_W + MB_W;
	localparam int DN_W = 64;  // divider numerator
	localparam int DD_W = 32;  // divider denominator

	// register indexes
	localparam logic [1:0] REG_BLEND  = 2'd0;
	localparam logic [1:0] REG_GYRO   = 2'd1;
	localparam logic [1:0] REG_OUTPUT = 2'd2;

	localparam logic [15:0] BLEND_RST  = 16'd32113;
	localparam logic [15:0] GYRO_RST   = 16'd22938;
	localparam logic [15:0] OUTPUT_RST = 16'd29491;
	localparam logic [15:0] ONE_Q15    = 16'd32768;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 28'sd39797;
	localparam logic signed [CW-1:0] DEG90       = 28'sd5898240;
	localparam logic signed [CW-1:0] DEG180      = 28'sd11796480;
	localparam logic signed [23:0]   TAN_SAT     = 24'sd4194304;

	localparam logic [DD_W-1:0]        RATE_DIV = 32'd4096000000;
	localparam logic signed [DN_W-1:0] RATE_HALF = 64'sd2048000000;

	typedef struct packed {
		logic                   start;
		logic                   vec;
		logic signed [CW-1:0]   x;
		logic signed [CW-1:0]   y;
		logic signed [CW-1:0]   z;
	} cfc_cordic_req_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} cfc_mul_req_t;

	typedef struct packed {
		logic                   start;
		logic [DN_W-1:0]        n;
		logic [DD_W-1:0]        d;
	} cfc_div_req_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic busy;
	} cfc_md_rsp_t;

	// atan(2^-i) in Q16 degrees
	function automatic logic signed [CW-1:0] atan_q16(input logic [4:0] i);
		logic signed [CW-1:0] v;
		case (i)
			5'd0:    v = 28'sd2949120;
			5'd1:    v = 28'sd1740967;
			5'd2:    v = 28'sd919879;
			5'd3:    v = 28'sd466945;
			5'd4:    v = 28'sd234379;
			5'd5:    v = 28'sd117304;
			5'd6:    v = 28'sd58666;
			5'd7:    v = 28'sd29335;
			5'd8:    v = 28'sd14668;
			5'd9:    v = 28'sd7334;
			5'd10:   v = 28'sd3667;
			5'd11:   v = 28'sd1833;
			5'd12:   v = 28'sd917;
			5'd13:   v = 28'sd458;
			5'd14:   v = 28'sd229;
			5'd15:   v = 28'sd115;
			5'd16:   v = 28'sd57;
			5'd17:   v = 28'sd29;
			5'd18:   v = 28'sd14;
			5'd19:   v = 28'sd7;
			5'd20:   v = 28'sd4;
			5'd21:   v = 28'sd2;
			5'd22:   v = 28'sd1;
			default: v = 28'sd0;
		endcase
		return v;
	endfunction

	// weights above one act as one
	function automatic logic [15:0] clamp_w(input logic [15:0] r);
		return (r > ONE_Q15) ? ONE_Q15 : r;
	endfunction

endpackage

// File: design/cfc_cordic.sv
module cfc_cordic #(
	parameter int unsigned STEPS = cfc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfc_pkg::cfc_cordic_req_t      req,
	output logic                          busy,
	output logic                          done,
	output logic signed [cfc_pkg::CW-1:0] x,
	output logic signed [cfc_pkg::CW-1:0] y,
	output logic signed [cfc_pkg::CW-1:0] z
);
	import cfc_pkg::*;

	localparam int IW = $clog2(STEPS + 1);

	logic [IW-1:0]        i_q;
	logic                 vec_q, busy_q, done_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic signed [CW-1:0] xs, ys, at;
	logic                 d;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = atan_q16(5'(i_q));
	// d: rotate toward negative angle (vectoring with y>0, rotation with z<0)
	assign d  = vec_q ? (y_q > 0) : (z_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vec;
			x_q   <= req.x;
			y_q   <= req.y;
			z_q   <= req.z;
		end else if (busy_q) begin
			if (d) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

// File: design/cfc_muldiv.sv
module cfc_muldiv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cfc_pkg::cfc_mul_req_t           mreq,
	input  cfc_pkg::cfc_div_req_t           dreq,
	output cfc_pkg::cfc_md_rsp_t            rsp,
	output logic signed [cfc_pkg::MP_W-1:0] prod,
	output logic [cfc_pkg::DN_W-1:0]        quo,
	output logic                            rem_nz
);
	import cfc_pkg::*;

	// shift-add multiplier, one bit of b per cycle
	logic [MA_W-1:0]         am_q, hi_q, a_mag;
	logic [MB_W-1:0]         lo_q, b_mag;
	logic                    mneg_q, mbusy_q, mdone_q;
	logic [$clog2(MB_W)-1:0] mcnt_q;
	logic [MA_W:0]           msum;
	logic [MP_W-1:0]         pmag;

	assign a_mag = mreq.a[MA_W-1] ? MA_W'(-mreq.a) : MA_W'(mreq.a);
	assign b_mag = mreq.b[MB_W-1] ? MB_W'(-mreq.b) : MB_W'(mreq.b);
	assign msum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, am_q} : '0);
	assign pmag  = {hi_q, lo_q};
	assign prod  = mneg_q ? -signed'(pmag) : signed'(pmag);

	// restoring divider, one quotient bit per cycle
	logic [DD_W-1:0]         d_q, rem_q;
	logic [DN_W-1:0]         quo_q;
	logic                    dbusy_q, ddone_q, ge;
	logic [$clog2(DN_W)-1:0] dcnt_q;
	logic [DD_W:0]           trial;

	assign trial  = {rem_q, quo_q[DN_W-1]};
	assign ge     = trial >= {1'b0, d_q};
	assign quo    = quo_q;
	assign rem_nz = (rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			ddone_q <= 1'b0;
			if (mreq.start) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == ($clog2(MB_W))'(MB_W - 1)) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
			if (dreq.start) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == ($clog2(DN_W))'(DN_W - 1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.start) begin
			am_q   <= a_mag;
			lo_q   <= b_mag;
			hi_q   <= '0;
			mneg_q <= mreq.a[MA_W-1] ^ mreq.b[MB_W-1];
		end else if (mbusy_q) begin
			hi_q <= msum[MA_W:1];
			lo_q <= {msum[0], lo_q[MB_W-1:1]};
		end
		if (dreq.start) begin
			d_q   <= dreq.d;
			rem_q <= '0;
			quo_q <= dreq.n;
		end else if (dbusy_q) begin
			rem_q <= ge ? DD_W'(trial - {1'b0, d_q}) : trial[DD_W-1:0];
			quo_q <= {quo_q[DN_W-2:0], ge};
		end
	end

	assign rsp.mul_done = mdone_q;
	assign rsp.div_done = ddone_q;
	assign rsp.busy     = mbusy_q | dbusy_q;

endmodule

// File: design/imu_roll_pitch_complementary_filter.sv
// channel | signals                                   | word
// --------+-------------------------------------------+-------------------------------
// in      | in_valid / in_ready                       | accel_x/y/z, gyro_x/y/z, time_step
// out     | out_valid / out_ready                     | roll_out, pitch_out
// cfg     | cfg_valid / cfg_ready, cfg_index          | cfg_data (16b Q1.15 weight)
//
// Each word runs through the shared serial units in turn: 16 shift-add multiplies,
// up to three divides, up to four CORDIC passes of CORDIC_STEPS iterations and a
// square root. in_ready is high only while idle; a finished word waits in the
// output register and the next input word is still taken, but the next result
// stalls until that register is freed. cfg_ready is always high.
// Reset clears weights to their defaults and all filter state to zero.
module imu_roll_pitch_complementary_filter #(
	parameter int unsigned CORDIC_STEPS    = cfc_pkg::CORDIC_STEPS_DEF,
	parameter int unsigned ANGLE_FRAC_BITS = cfc_pkg::ANGLE_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] roll_out,
	output logic signed [16:0] pitch_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import cfc_pkg::*;

	localparam int F = ANGLE_FRAC_BITS;
	localparam logic signed [23:0]   LIM    = 24'(180 << F);
	localparam logic signed [MP_W-1:0] LIMW = MP_W'(180 << F);
	localparam logic signed [CW-1:0] ARND   = CW'(1 << (15 - F));
	localparam logic signed [MP_W-1:0] H15  = MP_W'(16384);
	localparam logic signed [MP_W-1:0] H16  = MP_W'(32768);

	// sequencer steps
	localparam logic [4:0] ST_RX  = 5'd0;   // smooth gyro x
	localparam logic [4:0] ST_RY  = 5'd1;
	localparam logic [4:0] ST_RZ  = 5'd2;
	localparam logic [4:0] ST_AY2 = 5'd3;   // ay^2
	localparam logic [4:0] ST_AZ2 = 5'd4;   // + az^2
	localparam logic [4:0] ST_SQ  = 5'd5;   // magnitude
	localparam logic [4:0] ST_ACR = 5'd6;   // accel roll
	localparam logic [4:0] ST_ACP = 5'd7;   // accel pitch
	localparam logic [4:0] ST_SCR = 5'd8;   // sin/cos roll
	localparam logic [4:0] ST_SCP = 5'd9;   // sin/cos pitch
	localparam logic [4:0] ST_TAN = 5'd10;
	localparam logic [4:0] ST_T1A = 5'd11;
	localparam logic [4:0] ST_T1B = 5'd12;
	localparam logic [4:0] ST_RR  = 5'd13;  // roll rate
	localparam logic [4:0] ST_PRA = 5'd14;
	localparam logic [4:0] ST_PRB = 5'd15;  // pitch rate
	localparam logic [4:0] ST_GRM = 5'd16;  // roll increment
	localparam logic [4:0] ST_GRD = 5'd17;
	localparam logic [4:0] ST_GPM = 5'd18;  // pitch increment
	localparam logic [4:0] ST_GPD = 5'd19;
	localparam logic [4:0] ST_FR  = 5'd20;  // complementary blend
	localparam logic [4:0] ST_FP  = 5'd21;
	localparam logic [4:0] ST_NR  = 5'd22;  // output smoothing
	localparam logic [4:0] ST_NP  = 5'd23;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [4:0] pc_q;

	// config
	logic [15:0] wb_q, wg_q, wo_q, wb, wg, wo;

	// input word
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [15:0]        dt_q;

	// filter state
	logic signed [23:0] srx_q, sry_q, srz_q, roll_q, pitch_q;

	// scratch
	logic signed [23:0] acr_q, acp_q, tn_q;
	logic [23:0]        mag_q;
	logic signed [18:0] sr_q, cr_q, sp_q, cp_q;
	logic signed [26:0] t1_q;
	logic signed [33:0] rr_q, pr_q, gr_q, gp_q, fr_q, fp_q;
	logic signed [51:0] tmp_q;
	logic               neg_q;

	// output register
	logic               out_valid_q;
	logic signed [16:0] roll_out_q, pitch_out_q;

	// units
	cfc_mul_req_t       mreq;
	cfc_div_req_t       dreq;
	cfc_md_rsp_t        mrsp;
	cfc_cordic_req_t    creq;
	logic signed [MP_W-1:0] prod;
	logic [DN_W-1:0]    quo;
	logic               rem_nz;
	logic               cor_busy, cor_done;
	logic signed [CW-1:0] cor_x, cor_y, cor_z;

	// square root, one result bit per cycle
	logic               sq_start, sq_busy_q, sq_done_q;
	logic [47:0]        sq_vin, sq_v_q, sq_r_q, sq_bit_q, sq_cand;
	logic [4:0]         sq_cnt_q;

	// issue-side helpers
	logic               skip, neg_n;
	logic signed [23:0] skip_val;
	logic signed [CW-1:0] vx, vy, zr;
	logic signed [18:0] asp, acp;
	logic signed [DN_W-1:0] dn, qs, qf;
	logic signed [MP_W-1:0] p_r15, p_r16, nr;
	logic               unit_done;

	assign wb = clamp_w(wb_q);
	assign wg = clamp_w(wg_q);
	assign wo = clamp_w(wo_q);

	assign p_r15 = (prod + H15) >>> 15;
	assign p_r16 = (prod + H16) >>> 16;
	assign qs    = signed'(quo);
	assign qf    = neg_q ? -(qs + DN_W'(rem_nz)) : qs;  // floor for negative numerator
	assign asp   = sp_q[18] ? -sp_q : sp_q;
	assign acp   = cp_q[18] ? -cp_q : cp_q;
	assign unit_done = mrsp.mul_done | mrsp.div_done | cor_done | sq_done_q;

	cfc_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.dreq   (dreq),
		.rsp    (mrsp),
		.prod   (prod),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	cfc_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.busy   (cor_busy),
		.done   (cor_done),
		.x      (cor_x),
		.y      (cor_y),
		.z      (cor_z)
	);

	// step decode: operands for the unit a step uses
	always_comb begin
		mreq     = '0;
		dreq     = '0;
		creq     = '0;
		sq_start = 1'b0;
		sq_vin   = {tmp_q[31:0], 16'h0000};
		skip     = 1'b0;
		skip_val = '0;
		neg_n    = 1'b0;
		vx       = '0;
		vy       = '0;
		zr       = '0;
		dn       = '0;
		if (pc_q == ST_ACR) begin
			vy = CW'(signed'({ay_q, 8'h00}));
			vx = CW'(signed'({az_q, 8'h00}));
		end else begin
			vy = -CW'(signed'({ax_q, 8'h00}));
			vx = CW'({1'b0, mag_q});
		end
		zr = (pc_q == ST_SCR) ? (CW'(roll_q) <<< (16 - F)) : (CW'(pitch_q) <<< (16 - F));
		dn = (DN_W'(tmp_q) <<< F) + RATE_HALF;
		unique case (pc_q) inside
			ST_RX, ST_RY, ST_RZ: begin
				case (pc_q)
					ST_RX:   mreq.a = MA_W'(signed'({gx_q, 8'h00})) - MA_W'(srx_q);
					ST_RY:   mreq.a = MA_W'(signed'({gy_q, 8'h00})) - MA_W'(sry_q);
					default: mreq.a = MA_W'(signed'({gz_q, 8'h00})) - MA_W'(srz_q);
				endcase
				mreq.b = MB_W'({1'b0, wg});
				mreq.start = 1'b1;
			end
			ST_AY2: begin
				mreq.a = MA_W'(ay_q);
				mreq.b = MB_W'(ay_q);
				mreq.start = 1'b1;
			end
			ST_AZ2: begin
				mreq.a = MA_W'(az_q);
				mreq.b = MB_W'(az_q);
				mreq.start = 1'b1;
			end
			ST_SQ: sq_start = 1'b1;
			ST_ACR, ST_ACP: begin
				creq.vec = 1'b1;
				if (vx == '0 && vy == '0) begin
					skip = 1'b1;  // zero accelerometer vector: angle 0
				end else begin
					creq.start = 1'b1;
					if (vx < 0) begin
						creq.z = (vy >= 0) ? DEG180 : -DEG180;
						creq.x = -vx;
						creq.y = -vy;
					end else begin
						creq.x = vx;
						creq.y = vy;
					end
				end
			end
			ST_SCR, ST_SCP: begin
				creq.start = 1'b1;
				creq.x     = CORDIC_GAIN;
				if (zr > DEG90) begin
					creq.z = zr - DEG180;
					neg_n  = 1'b1;
				end else if (zr < -DEG90) begin
					creq.z = zr + DEG180;
					neg_n  = 1'b1;
				end else begin
					creq.z = zr;
				end
			end
			ST_TAN: begin
				neg_n = sp_q[18] != cp_q[18];
				if (25'(asp) >= {acp, 6'b000000}) begin
					// near +-90 deg pitch: tan saturates
					skip     = 1'b1;
					skip_val = neg_n ? -TAN_SAT : TAN_SAT;
				end else begin
					dreq.start = 1'b1;
					dreq.n     = DN_W'({asp[17:0], 16'h0000});
					dreq.d     = DD_W'(acp[17:0]);
				end
			end
			ST_T1A, ST_PRA: begin
				mreq.a = MA_W'(sry_q);
				mreq.b = MB_W'((pc_q == ST_T1A) ? sr_q : cr_q);
				mreq.start = 1'b1;
			end
			ST_T1B, ST_PRB: begin
				mreq.a = MA_W'(srz_q);
				mreq.b = MB_W'((pc_q == ST_T1B) ? cr_q : sr_q);
				mreq.start = 1'b1;
			end
			ST_RR: begin
				mreq.a = MA_W'(t1_q);
				mreq.b = MB_W'(tn_q);
				mreq.start = 1'b1;
			end
			ST_GRM, ST_GPM: begin
				mreq.a = MA_W'((pc_q == ST_GRM) ? rr_q : pr_q);
				mreq.b = MB_W'({1'b0, dt_q});
				mreq.start = 1'b1;
			end
			ST_GRD, ST_GPD: begin
				neg_n      = dn[DN_W-1];
				dreq.start = 1'b1;
				dreq.n     = neg_n ? DN_W'(-dn) : DN_W'(dn);
				dreq.d     = RATE_DIV;
			end
			ST_FR, ST_FP: begin
				mreq.a = (pc_q == ST_FR) ? MA_W'(gr_q) - MA_W'(acr_q)
				                         : MA_W'(gp_q) - MA_W'(acp_q);
				mreq.b = MB_W'({1'b0, wb});
				mreq.start = 1'b1;
			end
			ST_NR, ST_NP: begin
				mreq.a = (pc_q == ST_NR) ? MA_W'(fr_q) - MA_W'(roll_q)
				                         : MA_W'(fp_q) - MA_W'(pitch_q);
				mreq.b = MB_W'({1'b0, wo});
				mreq.start = 1'b1;
			end
			default: skip = 1'b1;
		endcase
		if (state_q != S_ISSUE) begin
			mreq.start = 1'b0;
			dreq.start = 1'b0;
			creq.start = 1'b0;
			sq_start   = 1'b0;
		end
	end

	// output smoothing plus saturation to +-180 deg
	always_comb begin
		nr = (pc_q == ST_NR) ? MP_W'(roll_q) + p_r15 : MP_W'(pitch_q) + p_r15;
		if (nr > LIMW) begin
			nr = LIMW;
		end else if (nr < -LIMW) begin
			nr = -LIMW;
		end
	end

	// digit-by-digit square root
	assign sq_cand = sq_r_q + sq_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (sq_start) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= '0;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
				if (sq_cnt_q == 5'd23) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_start) begin
			sq_v_q   <= sq_vin;
			sq_r_q   <= '0;
			sq_bit_q <= 48'h4000_0000_0000;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_cand) begin
				sq_v_q <= sq_v_q - sq_cand;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// sequencer, config and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= ST_RX;
			out_valid_q <= 1'b0;
			wb_q        <= BLEND_RST;
			wg_q        <= GYRO_RST;
			wo_q        <= OUTPUT_RST;
			srx_q       <= '0;
			sry_q       <= '0;
			srz_q       <= '0;
			roll_q      <= '0;
			pitch_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_BLEND:  wb_q <= cfg_data;
					REG_GYRO:   wg_q <= cfg_data;
					REG_OUTPUT: wo_q <= cfg_data;
					default:    ;
				endcase
			end
			// in S_DONE the output register reloads instead
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ISSUE;
						pc_q    <= ST_RX;
					end
				end
				S_ISSUE: begin
					if (skip) begin
						pc_q <= pc_q + 1'b1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (unit_done) begin
						case (pc_q)
							ST_RX: srx_q <= 24'(MP_W'(srx_q) + p_r15);
							ST_RY: sry_q <= 24'(MP_W'(sry_q) + p_r15);
							ST_RZ: srz_q <= 24'(MP_W'(srz_q) + p_r15);
							ST_NR: roll_q  <= 24'(nr);
							ST_NP: pitch_q <= 24'(nr);
							default: ;
						endcase
						if (pc_q == ST_NP) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_ISSUE;
							pc_q    <= pc_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			gx_q <= gyro_x;
			gy_q <= gyro_y;
			gz_q <= gyro_z;
			dt_q <= time_step;
		end
		if (state_q == S_ISSUE) begin
			neg_q <= neg_n;
			if (skip) begin
				if (pc_q == ST_ACR) acr_q <= skip_val;
				if (pc_q == ST_ACP) acp_q <= skip_val;
				if (pc_q == ST_TAN) tn_q  <= skip_val;
			end
		end
		if (state_q == S_WAIT && unit_done) begin
			case (pc_q)
				ST_AY2: tmp_q <= 52'(prod);
				ST_AZ2: tmp_q <= tmp_q + 52'(prod);
				ST_SQ:  mag_q <= sq_r_q[23:0];
				ST_ACR: acr_q <= 24'((cor_z + ARND) >>> (16 - F));
				ST_ACP: acp_q <= 24'((cor_z + ARND) >>> (16 - F));
				ST_SCR: begin
					sr_q <= 19'(neg_q ? -cor_y : cor_y);
					cr_q <= 19'(neg_q ? -cor_x : cor_x);
				end
				ST_SCP: begin
					sp_q <= 19'(neg_q ? -cor_y : cor_y);
					cp_q <= 19'(neg_q ? -cor_x : cor_x);
				end
				ST_TAN: tn_q  <= 24'(neg_q ? -qs : qs);
				ST_T1A, ST_PRA, ST_GRM, ST_GPM: tmp_q <= 52'(prod);
				ST_T1B: t1_q  <= 27'((MP_W'(tmp_q) + prod + H16) >>> 16);
				ST_RR:  rr_q  <= 34'(MP_W'(srx_q) + p_r16);
				ST_PRB: pr_q  <= 34'((MP_W'(tmp_q) - prod + H16) >>> 16);
				ST_GRD: gr_q  <= 34'(DN_W'(roll_q) + qf);
				ST_GPD: gp_q  <= 34'(DN_W'(pitch_q) + qf);
				ST_FR:  fr_q  <= 34'(MP_W'(acr_q) + p_r15);
				ST_FP:  fp_q  <= 34'(MP_W'(acp_q) + p_r15);
				default: ;
			endcase
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			roll_out_q  <= roll_q[16:0];
			pitch_out_q <= pitch_q[16:0];
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign roll_out  = roll_out_q;
	assign pitch_out = pitch_out_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_angle_sat: assert property (@(posedge clk) disable iff (!arst_n)
		roll_q <= LIM && roll_q >= -LIM && pitch_q <= LIM && pitch_q >= -LIM)
		else $error("angle state outside +-180 deg");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_ISSUE && pc_q == ST_RX))
		else $error("accepted word did not start at first step");

	a_unit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(mrsp.busy || cor_busy || sq_busy_q) |-> state_q == S_WAIT)
		else $error("unit running outside wait state");

	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({mrsp.mul_done, mrsp.div_done, cor_done, sq_done_q}) <= 1)
		else $error("two units finished at once");
`endif

endmodule

// File: tb/tb_imu_roll_pitch_complementary_filter.sv
module tb_imu_roll_pitch_complementary_filter;
	import cfc_pkg::*;

	localparam int ANG_F = 8;        // angle fraction bits (block default)
	localparam int N_STEP = 16;      // CORDIC iterations (block default)
	localparam int TAN_CAP = 64;     // tan(pitch) clamp
	localparam longint RATE_DEN = 64'sd4096000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
	logic [15:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [16:0] roll_out, pitch_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_BLEND;
	logic [15:0] cfg_data = '0;

	imu_roll_pitch_complementary_filter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z), .time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.roll_out(roll_out), .pitch_out(pitch_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: our own copy of weights and filter memory.
	// ---------------------------------------------------------------
	logic [15:0] w_blend, w_gyro, w_out;
	longint rate_x, rate_y, rate_z, roll_st, pitch_st;

	typedef struct packed {
		logic signed [16:0] roll;
		logic signed [16:0] pitch;
	} angle_pair_t;

	angle_pair_t angles_due[$];
	int errors = 0;
	bit idle_on = 1'b1;   // random idling enable for both sides

	function automatic longint floor_shr(longint v, int s);
		return (v >= 0) ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint clip(longint v, longint lim);
		return (v > lim) ? lim : ((v < -lim) ? -lim : v);
	endfunction

	// Q1.15 weighted mix, rounded half up
	function automatic longint mix_q15(longint a, longint b, logic [15:0] r);
		longint w;
		w = (r > 16'd32768) ? 32768 : longint'(r);
		return floor_shr(a * w + b * (32768 - w) + 16384, 15);
	endfunction

	function automatic longint atan_step(int i);
		return longint'(atan_q16(i[4:0]));
	endfunction

	// rotation mode: angle in 1/2^F deg -> Q16 sin, cos
	task automatic rot_sincos(input longint a, output longint s, output longint c);
		longint z, x, y, nx, ny;
		bit flip;
		z = clip(a, 180 <<< ANG_F) * (1 <<< (16 - ANG_F));
		x = 39797; y = 0; flip = 0;
		if (z > 90 * 65536) begin
			z -= 180 * 65536; flip = 1;
		end else if (z < -90 * 65536) begin
			z += 180 * 65536; flip = 1;
		end
		for (int i = 0; i < N_STEP; i++) begin
			if (z >= 0) begin
				nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_step(i);
			end else begin
				nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_step(i);
			end
			x = nx; y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// vectoring mode: atan2(y, x) in 1/2^F deg
	function automatic longint vec_atan2(longint y, longint x);
		longint z, nx, ny;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x; y = -y;
		end
		for (int i = 0; i < N_STEP; i++) begin
			if (y > 0) begin
				nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_step(i);
			end else begin
				nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_step(i);
			end
			x = nx; y = ny;
		end
		return floor_shr(z + (1 <<< (15 - ANG_F)), 16 - ANG_F);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// floor division, then round half up
	function automatic longint div_round(longint n, longint d);
		longint q, r;
		q = n / d; r = n % d;
		if (r < 0) begin
			q--; r += d;
		end
		if (2 * r >= d) q++;
		return q;
	endfunction

	// One filter update; pushes the expected angle pair.
	task automatic fuse_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz,
			input logic [15:0] dt);
		longint acc_r, acc_p, mag, sr, cr, sp, cp, tn, t1, rr, pr, g_r, g_p, f_r, f_p;
		longint asp, acp;
		angle_pair_t e;
		rate_x = mix_q15(longint'(gx) * 256, rate_x, w_gyro);
		rate_y = mix_q15(longint'(gy) * 256, rate_y, w_gyro);
		rate_z = mix_q15(longint'(gz) * 256, rate_z, w_gyro);
		acc_r = vec_atan2(longint'(ay) * 256, longint'(az) * 256);
		mag = int_sqrt(longint'(longint'(ay) * ay + longint'(az) * az) << 16);
		acc_p = vec_atan2(-longint'(ax) * 256, mag);
		rot_sincos(roll_st, sr, cr);
		rot_sincos(pitch_st, sp, cp);
		asp = (sp < 0) ? -sp : sp;
		acp = (cp < 0) ? -cp : cp;
		if (asp >= TAN_CAP * acp) begin
			tn = TAN_CAP * 65536;
			if ((sp < 0) != (cp < 0)) tn = -tn;
		end else tn = (sp * 65536) / cp;
		t1 = floor_shr(sr * rate_y + cr * rate_z + 32768, 16);
		rr = rate_x + floor_shr(tn * t1 + 32768, 16);
		pr = floor_shr(cr * rate_y - sr * rate_z + 32768, 16);
		g_r = roll_st + div_round(rr * longint'(dt) * (1 <<< ANG_F), RATE_DEN);
		g_p = pitch_st + div_round(pr * longint'(dt) * (1 <<< ANG_F), RATE_DEN);
		f_r = mix_q15(g_r, acc_r, w_blend);
		f_p = mix_q15(g_p, acc_p, w_blend);
		roll_st = clip(mix_q15(f_r, roll_st, w_out), 180 <<< ANG_F);
		pitch_st = clip(mix_q15(f_p, pitch_st, w_out), 180 <<< ANG_F);
		e.roll = roll_st[16:0];
		e.pitch = pitch_st[16:0];
		angles_due.push_back(e);
	endtask

	// Send one sample word; valid holds until accepted.
	task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz,
			input logic [15:0] dt);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 34) @(negedge clk);
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		gyro_x <= gx; gyro_y <= gy; gyro_z <= gz; time_step <= dt;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fuse_sample(ax, ay, az, gx, gy, gz, dt);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Output side: random back-pressure, sampled at the rising edge.
	always @(negedge clk) out_ready <= !(idle_on && $urandom_range(99) < 34);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (angles_due.size() == 0) begin
				$display("%0t: unexpected word roll=%0d pitch=%0d", $time, roll_out, pitch_out);
				errors++;
			end else begin
				angle_pair_t e;
				e = angles_due.pop_front();
				if (roll_out !== e.roll) begin
					$display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_out);
					errors++;
				end
				if (pitch_out !== e.pitch) begin
					$display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_out);
					errors++;
				end
			end
		end
	end

	task automatic drain;
		while (angles_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Register write; only called with nothing in flight.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BLEND:  w_blend = val;
			REG_GYRO:   w_gyro = val;
			REG_OUTPUT: w_out = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random(input int n, input bit tiny_dt);
		for (int k = 0; k < n; k++) begin
			logic [15:0] dt;
			dt = tiny_dt ? 16'($urandom_range(0, 3000)) : 16'($urandom);
			if ($urandom_range(9) == 0) dt = 16'hFFFF;
			send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), dt);
		end
	endtask

	// Extremes of every field, zero accel vector, zero time step.
	task automatic test_directed;
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(0, 0, 0, 32767, 32767, 32767, 16'hFFFF);
		send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 16'hFFFF);
		send_sample(32767, 32767, 32767, 0, 0, 0, 1000);
		send_sample(0, 0, -32768, 0, 0, 0, 1000);       // roll toward 180
		send_sample(0, -1, -32768, 0, 0, 0, 1000);      // roll toward -180
		send_sample(-32768, 0, 0, 0, 0, 0, 1000);       // pitch +90 with zero y/z
		send_sample(32767, 0, 0, 0, 0, 0, 1000);
		send_sample(0, 16384, 0, -32768, 0, 0, 0);      // no elapsed time
		send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
			16'hAAAA);
		drain();
	endtask

	// Drive pitch near +-90 to hit the tan clamp, with full-rate gyro.
	task automatic test_gimbal;
		write_reg(REG_BLEND, 16'd0);
		write_reg(REG_OUTPUT, 16'd32768);
		send_sample(-32768, 0, 1, 1000, 32767, -32768, 16'hFFFF);
		send_sample(-32768, 0, 0, -32768, 32767, 32767, 16'hFFFF);
		send_sample(32767, 0, 0, 32767, -32768, 32767, 16'hFFFF);
		send_sample(32767, 1, 0, 32767, 32767, 32767, 16'hFFFF);
		drain();
	endtask

	// Weight extremes, including values above one.
	task automatic test_weights;
		logic [15:0] vals[6] = '{16'd0, 16'd32768, 16'd65535, 16'd32769, 16'd1, 16'd16384};
		foreach (vals[i]) begin
			write_reg(REG_BLEND, vals[i]);
			write_reg(REG_GYRO, vals[(i + 1) % 6]);
			write_reg(REG_OUTPUT, vals[(i + 2) % 6]);
			send_random(30, i[0]);
			drain();
		end
	endtask

	// Bulk random traffic; long stretch with idling off in the middle.
	task automatic test_random;
		write_reg(REG_BLEND, BLEND_RST);
		write_reg(REG_GYRO, GYRO_RST);
		write_reg(REG_OUTPUT, OUTPUT_RST);
		send_random(600, 1'b1);
		idle_on = 1'b0;
		send_random(300, 1'b0);
		idle_on = 1'b1;
		drain();
		write_reg(REG_BLEND, 16'($urandom_range(0, 65535)));
		write_reg(REG_GYRO, 16'($urandom_range(0, 32768)));
		write_reg(REG_OUTPUT, 16'($urandom_range(0, 32768)));
		send_random(700, 1'b1);
		drain();
	endtask

	initial begin
		w_blend = BLEND_RST; w_gyro = GYRO_RST; w_out = OUTPUT_RST;
		rate_x = 0; rate_y = 0; rate_z = 0; roll_st = 0; pitch_st = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_gimbal();
		test_weights();
		test_random();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// ~1800 words plus stalls; ample margin
	initial begin
		#50000000;
		$display("status: fail");
		$finish;
	end

endmodule
